FILE: src/tdf_pkg.sv
package tdf_pkg;

	localparam int unsigned MAX_RESULTS = 32;
	localparam int unsigned COUNT_W = $clog2(MAX_RESULTS);

	typedef logic [3:0] step_t;

	localparam step_t ST_IDLE      = 4'd0;
	localparam step_t ST_CHECK     = 4'd1;
	localparam step_t ST_DIV_START = 4'd2;
	localparam step_t ST_DIV_WAIT  = 4'd3;
	localparam step_t ST_TEST_END  = 4'd4;
	localparam step_t ST_TEST_REM  = 4'd5;
	localparam step_t ST_TEST_FULL = 4'd6;
	localparam step_t ST_EMIT_MID  = 4'd7;
	localparam step_t ST_INC       = 4'd8;
	localparam step_t ST_EMIT_LAST = 4'd9;

	typedef enum logic [2:0] {
		C_NEVER    = 3'd0,
		C_ALWAYS   = 3'd1,
		C_IN_VALID = 3'd2,
		C_SMALL    = 3'd3,
		C_DIV_DONE = 3'd4,
		C_Q_LT_D   = 3'd5,
		C_R_NZ     = 3'd6,
		C_OUT_FREE = 3'd7
	} cond_t;

	typedef struct packed {
		cond_t cond;
		logic  hold;
		step_t target;
		logic  load;
		logic  start;
		logic  emit_mid;
		logic  emit_last;
		logic  inc;
		logic  full_chk;
	} ctrl_word_t;

	function automatic ctrl_word_t ucode(step_t s);
		ctrl_word_t w;
		w = '{cond: C_NEVER, hold: 1'b0, target: ST_IDLE, load: 1'b0, start: 1'b0,
			emit_mid: 1'b0, emit_last: 1'b0, inc: 1'b0, full_chk: 1'b0};
		case (s)
			ST_IDLE: begin
				w.cond = C_IN_VALID; w.hold = 1'b1; w.target = ST_CHECK; w.load = 1'b1;
			end
			ST_CHECK: begin
				w.cond = C_SMALL; w.target = ST_EMIT_LAST;
			end
			ST_DIV_START: begin
				w.start = 1'b1;
			end
			ST_DIV_WAIT: begin
				w.cond = C_DIV_DONE; w.hold = 1'b1; w.target = ST_TEST_END;
			end
			ST_TEST_END: begin
				w.cond = C_Q_LT_D; w.target = ST_EMIT_LAST;
			end
			ST_TEST_REM: begin
				w.cond = C_R_NZ; w.target = ST_INC;
			end
			ST_TEST_FULL: begin
				w.cond = C_NEVER; w.full_chk = 1'b1; w.target = ST_EMIT_LAST;
			end
			ST_EMIT_MID: begin
				w.cond = C_OUT_FREE; w.hold = 1'b1; w.target = ST_DIV_START;
				w.emit_mid = 1'b1;
			end
			ST_INC: begin
				w.cond = C_ALWAYS; w.target = ST_DIV_START; w.inc = 1'b1;
			end
			ST_EMIT_LAST: begin
				w.cond = C_OUT_FREE; w.hold = 1'b1; w.target = ST_IDLE;
				w.emit_last = 1'b1;
			end
			default: begin
				w.cond = C_ALWAYS; w.target = ST_IDLE;
			end
		endcase
		return w;
	endfunction

endpackage

FILE: src/tdf_num_if.sv
interface tdf_num_if #(
	parameter int unsigned VALUE_WIDTH = 32
);
	logic                   valid;
	logic                   ready;
	logic [VALUE_WIDTH-1:0] number_in;

	modport source (output valid, output number_in, input ready);
	modport sink (input valid, input number_in, output ready);
endinterface

FILE: src/tdf_fac_if.sv
interface tdf_fac_if #(
	parameter int unsigned VALUE_WIDTH = 32
);
	logic                   valid;
	logic                   ready;
	logic [VALUE_WIDTH-1:0] factor_out;
	logic                   last_factor;

	modport source (output valid, output factor_out, output last_factor, input ready);
	modport sink (input valid, input factor_out, input last_factor, output ready);
endinterface

FILE: src/tdf_divider.sv
module tdf_divider import tdf_pkg::*; #(
	parameter int unsigned VALUE_WIDTH = 32
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	input  logic [VALUE_WIDTH-1:0] dividend,
	input  logic [VALUE_WIDTH-1:0] divisor,
	output logic                   busy,
	output logic [VALUE_WIDTH-1:0] quotient,
	output logic [VALUE_WIDTH-1:0] remainder
);
	localparam int unsigned CNT_W = $clog2(VALUE_WIDTH + 1);

	logic                   busy_q;
	logic [CNT_W-1:0]       cnt_q;
	logic [VALUE_WIDTH-1:0] acc_q;
	logic [VALUE_WIDTH-1:0] quo_q;
	logic [VALUE_WIDTH:0]   shifted;
	logic [VALUE_WIDTH:0]   diff;

	// One quotient bit per cycle, restoring form.
	assign shifted = {acc_q, quo_q[VALUE_WIDTH-1]};
	assign diff    = shifted - {1'b0, divisor};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CNT_W'(VALUE_WIDTH);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CNT_W'(1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			acc_q <= '0;
			quo_q <= dividend;
		end else if (busy_q) begin
			if (!diff[VALUE_WIDTH]) begin
				acc_q <= diff[VALUE_WIDTH-1:0];
				quo_q <= {quo_q[VALUE_WIDTH-2:0], 1'b1};
			end else begin
				acc_q <= shifted[VALUE_WIDTH-1:0];
				quo_q <= {quo_q[VALUE_WIDTH-2:0], 1'b0};
			end
		end
	end

	assign busy      = busy_q;
	assign quotient  = quo_q;
	assign remainder = acc_q;
endmodule

FILE: src/trial_division_factorizer.sv
// Channel  Dir  Payload                      Handshake
// num      in   number_in                    valid / ready
// fac      out  factor_out, last_factor      valid / ready
//
// One request at a time: a shift-subtract divider runs one trial per divisor tested,
// and each trial is one pass through the divide and test steps of the microprogram.
// A number needs one trial per factor found plus one per divisor tried up to its
// square root. Inputs 0 and 1 bypass the divider and go from the check step
// straight to the final result. Reset is asynchronous and clears control.
// A stalled result holds the sequencer at its emit step; the next request is taken
// while the final result still waits in the output register.
module trial_division_factorizer import tdf_pkg::*; #(
	parameter int unsigned VALUE_WIDTH = 32
) (
	input  logic clk,
	input  logic arst_n,
	tdf_num_if.sink   num,
	tdf_fac_if.source fac
);
	step_t                  step_q;
	ctrl_word_t             word;
	logic                   go;
	logic                   act;
	logic [VALUE_WIDTH-1:0] rem_q;
	logic [VALUE_WIDTH-1:0] div_q;
	logic [COUNT_W-1:0]     count_q;
	logic [VALUE_WIDTH-1:0] quotient;
	logic [VALUE_WIDTH-1:0] remainder;
	logic                   div_start;
	logic                   div_busy;
	logic                   out_free;
	logic                   fac_valid_q;
	logic [VALUE_WIDTH-1:0] fac_factor_q;
	logic                   fac_last_q;

	assign word     = ucode(step_q);
	assign out_free = !fac_valid_q || fac.ready;

	always_comb begin
		case (word.cond)
			C_NEVER:    go = word.full_chk && (count_q == COUNT_W'(MAX_RESULTS - 1));
			C_ALWAYS:   go = 1'b1;
			C_IN_VALID: go = num.valid;
			C_SMALL:    go = (rem_q[VALUE_WIDTH-1:1] == '0);
			C_DIV_DONE: go = !div_busy;
			C_Q_LT_D:   go = (quotient < div_q);
			C_R_NZ:     go = (remainder != '0);
			C_OUT_FREE: go = out_free;
			default:    go = 1'b0;
		endcase
	end

	assign act       = word.hold ? go : 1'b1;
	assign div_start = word.start;
	assign num.ready = word.load;

	tdf_divider #(.VALUE_WIDTH(VALUE_WIDTH)) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start),
		.dividend  (rem_q),
		.divisor   (div_q),
		.busy      (div_busy),
		.quotient  (quotient),
		.remainder (remainder)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q      <= ST_IDLE;
			fac_valid_q <= 1'b0;
		end else begin
			if (go) begin
				step_q <= word.target;
			end else if (!word.hold) begin
				step_q <= step_q + 1'b1;
			end
			if (act && (word.emit_mid || word.emit_last)) begin
				fac_valid_q <= 1'b1;
			end else if (fac.ready) begin
				fac_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (act && word.load) begin
			rem_q   <= num.number_in;
			div_q   <= VALUE_WIDTH'(2);
			count_q <= '0;
		end
		if (act && word.inc) begin
			div_q <= div_q + 1'b1;
		end
		if (act && word.emit_mid) begin
			fac_factor_q <= div_q;
			fac_last_q   <= 1'b0;
			rem_q        <= quotient;
			count_q      <= count_q + 1'b1;
		end
		if (act && word.emit_last) begin
			fac_factor_q <= rem_q;
			fac_last_q   <= 1'b1;
		end
	end

	assign fac.valid       = fac_valid_q;
	assign fac.factor_out  = fac_factor_q;
	assign fac.last_factor = fac_last_q;
endmodule

FILE: src/tdf_checker.sv
module tdf_checker #(
	parameter int unsigned VALUE_WIDTH = 32
) (
	input logic                   clk,
	input logic                   arst_n,
	input logic                   num_valid,
	input logic                   num_ready,
	input logic                   fac_valid,
	input logic                   fac_ready,
	input logic [VALUE_WIDTH-1:0] factor_out,
	input logic                   last_factor
);
	// A stalled result keeps its value.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		fac_valid && !fac_ready |=> fac_valid && $stable(factor_out) && $stable(last_factor))
		else $error("result changed while stalled");

	// Only one request is worked on at a time.
	a_one: assert property (@(posedge clk) disable iff (!arst_n)
		num_valid && num_ready |=> !num_ready)
		else $error("request taken while another is in work");

	// A zero result is always the final one.
	a_zero: assert property (@(posedge clk) disable iff (!arst_n)
		fac_valid && (factor_out == '0) |-> last_factor)
		else $error("zero result without last flag");

	// Factors found by division are at least two.
	a_small: assert property (@(posedge clk) disable iff (!arst_n)
		fac_valid && !last_factor |-> factor_out[VALUE_WIDTH-1:1] != '0)
		else $error("intermediate factor below two");
endmodule

bind trial_division_factorizer tdf_checker #(.VALUE_WIDTH(VALUE_WIDTH)) u_chk (
	.clk         (clk),
	.arst_n      (arst_n),
	.num_valid   (num.valid),
	.num_ready   (num.ready),
	.fac_valid   (fac.valid),
	.fac_ready   (fac.ready),
	.factor_out  (fac.factor_out),
	.last_factor (fac.last_factor)
);
